/* rtl/morse_pkg.sv */
// Package with the character code tables and decode helpers of the Morse keyer.
package morse_pkg;

	localparam int CharW = 8;
	localparam int TickW = 8;
	localparam int LenW = 3;
	localparam int PatW = 5;
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_DIT = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_DAH = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ELEM_GAP = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_CHAR_GAP = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_WORD_GAP = 3'd4;

	localparam logic [CharW-1:0] ASCII_SPACE = 8'd32;
	localparam logic [CharW-1:0] ASCII_LOWER_A = 8'd97;
	localparam logic [CharW-1:0] ASCII_LOWER_Z = 8'd122;
	localparam logic [CharW-1:0] ASCII_UPPER_A = 8'd65;
	localparam logic [CharW-1:0] ASCII_UPPER_Z = 8'd90;
	localparam logic [CharW-1:0] ASCII_ZERO = 8'd48;
	localparam logic [CharW-1:0] ASCII_NINE = 8'd57;

	// Each entry: element count in bits 7..5, pattern in bits 4..0, MSB first, 1 is a dash.
	localparam logic [7:0] LETTER_TAB [26] = '{
		8'h41, 8'h88, 8'h8A, 8'h64, 8'h20,
		8'h82, 8'h66, 8'h80, 8'h40, 8'h87,
		8'h65, 8'h84, 8'h43, 8'h42, 8'h67,
		8'h86, 8'h8D, 8'h62, 8'h60, 8'h21,
		8'h61, 8'h81, 8'h63, 8'h89, 8'h8B,
		8'h8C
	};

	localparam logic [7:0] DIGIT_TAB [10] = '{
		8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1,
		8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE
	};

	typedef struct packed {
		logic is_space;
		logic is_bad;
		logic [LenW-1:0] len;
		logic [PatW-1:0] pat;
	} char_info_t;

	// The pattern comes back left-aligned so that the first element sits in the top bit.
	function automatic char_info_t decode_char(input logic [CharW-1:0] c);
		char_info_t info;
		logic [7:0] entry;
		logic [CharW-1:0] offs;
		info = '0;
		entry = '0;
		offs = '0;
		if (c == ASCII_SPACE) begin
			info.is_space = 1'b1;
		end else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
			offs = c - ASCII_LOWER_A;
			entry = LETTER_TAB[offs[4:0]];
		end else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
			offs = c - ASCII_UPPER_A;
			entry = LETTER_TAB[offs[4:0]];
		end else if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
			offs = c - ASCII_ZERO;
			entry = DIGIT_TAB[offs[3:0]];
		end else begin
			info.is_bad = 1'b1;
		end
		info.len = entry[7:5];
		info.pat = PatW'(entry[4:0] << (LenW'(PatW) - entry[7:5]));
		return info;
	endfunction

endpackage

/* rtl/morse_code_keyer.sv */
// Morse keyer top level: turns ASCII character words into key segment words.
// One character is accepted when the block is idle; the sequencer then hands one
// segment a cycle to the output register while the output side does not stall, and
// takes no new character until the last segment is handed on. The segment
// sequencer holds the character in its pattern shift register and element counter.
// The user writes registers through the cfg port only while the block is idle;
// the block itself does not enforce this.
module morse_code_keyer
	import morse_pkg::*;
#(
	parameter int MAX_ELEMENTS = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [TickW-1:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata, // char_code
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [15:0] m_axis_tdata, // key_on, duration_ticks, zero fill
	output logic m_axis_tuser, // bad_char
	output logic m_axis_tlast
);

	localparam int ElemW = $clog2(MAX_ELEMENTS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FIRST = 2'd1;
	localparam logic [1:0] ST_ON = 2'd2;
	localparam logic [1:0] ST_OFF = 2'd3;

	logic [1:0] state_q, state_d;
	logic [TickW-1:0] dit_q, dah_q, elem_gap_q, char_gap_q, word_gap_q;
	logic space_q, bad_q;
	logic [PatW-1:0] pat_q;
	logic [ElemW-1:0] cnt_q;
	logic out_valid_q, out_key_q, out_bad_q, out_last_q;
	logic [TickW-1:0] out_dur_q;

	char_info_t info;
	logic accept, emit;
	logic seg_key, seg_last;
	logic [TickW-1:0] seg_dur;

	assign info = decode_char(s_axis_tdata);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign emit = (state_q != ST_IDLE) && (!out_valid_q || m_axis_tready);

	always_comb begin
		seg_key = 1'b0;
		seg_last = 1'b0;
		seg_dur = char_gap_q;
		state_d = state_q;
		unique case (state_q)
			ST_FIRST: begin
				if (space_q) begin
					seg_dur = word_gap_q;
					seg_last = 1'b1;
					state_d = ST_IDLE;
				end else if (bad_q || cnt_q == '0) begin
					seg_last = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_ON;
				end
			end
			ST_ON: begin
				seg_key = 1'b1;
				seg_dur = pat_q[PatW-1] ? dah_q : dit_q;
				state_d = ST_OFF;
			end
			ST_OFF: begin
				seg_dur = elem_gap_q;
				seg_last = (cnt_q == ElemW'(1));
				state_d = seg_last ? ST_IDLE : ST_ON;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dit_q <= 8'd2;
			dah_q <= 8'd5;
			elem_gap_q <= 8'd2;
			char_gap_q <= 8'd5;
			word_gap_q <= 8'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIT: dit_q <= cfg_data;
				REG_DAH: dah_q <= cfg_data;
				REG_ELEM_GAP: elem_gap_q <= cfg_data;
				REG_CHAR_GAP: char_gap_q <= cfg_data;
				REG_WORD_GAP: word_gap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= ST_FIRST;
			end else if (emit) begin
				state_q <= state_d;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			space_q <= info.is_space;
			bad_q <= info.is_bad;
			pat_q <= info.pat;
			cnt_q <= (32'(info.len) < MAX_ELEMENTS) ? ElemW'(info.len) : ElemW'(MAX_ELEMENTS);
		end else if (emit && state_q == ST_OFF) begin
			pat_q <= {pat_q[PatW-2:0], 1'b0};
			cnt_q <= cnt_q - ElemW'(1);
		end
		if (emit) begin
			out_key_q <= seg_key;
			out_dur_q <= seg_dur;
			out_bad_q <= bad_q && state_q == ST_FIRST;
			out_last_q <= seg_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'd0, out_dur_q, out_key_q};
	assign m_axis_tuser = out_bad_q;
	assign m_axis_tlast = out_last_q;

`ifndef ASSERT_OFF
	a_key_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tlast && !m_axis_tuser)
		else $error("keyed segment marked last or bad");

	a_bad_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("bad character produced more than one segment");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready right after accepting a character");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> 32'(cnt_q) <= MAX_ELEMENTS)
		else $error("element counter beyond limit");
`endif

endmodule

/* bench/morse_code_keyer_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the Morse keyer: directed table, then random characters.
module morse_code_keyer_test;
	import morse_pkg::*;

	localparam int KEYED_LIMIT = 5;

	typedef struct packed {
		logic key_on;
		logic [TickW-1:0] ticks;
		logic bad;
		logic last;
	} segment_t;

	typedef struct packed {
		logic [CharW-1:0] ch;
		logic typed;
		logic [TickW-1:0] ticks;
		logic bad;
	} row_t;

	// Rows marked typed give a single silent segment read straight off the reset settings.
	localparam row_t DIRECTED [24] = '{
		'{8'h20, 1'b1, 8'd8, 1'b0}, '{8'h00, 1'b1, 8'd5, 1'b1},
		'{8'hFF, 1'b1, 8'd5, 1'b1}, '{8'h80, 1'b1, 8'd5, 1'b1},
		'{8'h7F, 1'b1, 8'd5, 1'b1}, '{8'h40, 1'b1, 8'd5, 1'b1},
		'{8'h5B, 1'b1, 8'd5, 1'b1}, '{8'h60, 1'b1, 8'd5, 1'b1},
		'{8'h7B, 1'b1, 8'd5, 1'b1}, '{8'h2F, 1'b1, 8'd5, 1'b1},
		'{8'h3A, 1'b1, 8'd5, 1'b1}, '{8'h2E, 1'b1, 8'd5, 1'b1},
		'{8'h41, 1'b0, 8'd0, 1'b0}, '{8'h5A, 1'b0, 8'd0, 1'b0},
		'{8'h61, 1'b0, 8'd0, 1'b0}, '{8'h7A, 1'b0, 8'd0, 1'b0},
		'{8'h45, 1'b0, 8'd0, 1'b0}, '{8'h54, 1'b0, 8'd0, 1'b0},
		'{8'h51, 1'b0, 8'd0, 1'b0}, '{8'h79, 1'b0, 8'd0, 1'b0},
		'{8'h30, 1'b0, 8'd0, 1'b0}, '{8'h31, 1'b0, 8'd0, 1'b0},
		'{8'h35, 1'b0, 8'd0, 1'b0}, '{8'h39, 1'b0, 8'd0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [TickW-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	logic [TickW-1:0] tick_regs [5];
	segment_t pending_segments [$];
	int mismatches = 0;
	bit calm = 1'b0;

	morse_code_keyer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	function automatic string morse_of(input logic [CharW-1:0] up);
		case (up)
			"A": return ".-";    "B": return "-...";  "C": return "-.-.";  "D": return "-..";
			"E": return ".";     "F": return "..-.";  "G": return "--.";   "H": return "....";
			"I": return "..";    "J": return ".---";  "K": return "-.-";   "L": return ".-..";
			"M": return "--";    "N": return "-.";    "O": return "---";   "P": return ".--.";
			"Q": return "--.-";  "R": return ".-.";   "S": return "...";   "T": return "-";
			"U": return "..-";   "V": return "...-";  "W": return ".--";   "X": return "-..-";
			"Y": return "-.--";  "Z": return "--..";
			"0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
			"4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
			"8": return "---.."; "9": return "----.";
			default: return "";
		endcase
	endfunction

	function automatic void predict_segments(input logic [CharW-1:0] c);
		logic [CharW-1:0] up;
		string code;
		int n;
		if (c == ASCII_SPACE) begin
			pending_segments.push_back(segment_t'{1'b0, tick_regs[REG_WORD_GAP], 1'b0, 1'b1});
			return;
		end
		up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		code = morse_of(up);
		if (code.len() == 0) begin
			pending_segments.push_back(segment_t'{1'b0, tick_regs[REG_CHAR_GAP], 1'b1, 1'b1});
			return;
		end
		n = code.len() < KEYED_LIMIT ? code.len() : KEYED_LIMIT;
		pending_segments.push_back(segment_t'{1'b0, tick_regs[REG_CHAR_GAP], 1'b0, 1'b0});
		for (int i = 0; i < n; i++) begin
			pending_segments.push_back(segment_t'{1'b1,
				code[i] == "-" ? tick_regs[REG_DAH] : tick_regs[REG_DIT], 1'b0, 1'b0});
			pending_segments.push_back(segment_t'{1'b0, tick_regs[REG_ELEM_GAP], 1'b0,
				i == n - 1});
		end
	endfunction

	function automatic logic [CharW-1:0] random_char();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return CharW'("A" + $urandom_range(0, 25));
		if (pick < 65)
			return CharW'("a" + $urandom_range(0, 25));
		if (pick < 80)
			return CharW'("0" + $urandom_range(0, 9));
		if (pick < 88)
			return ASCII_SPACE;
		return CharW'($urandom_range(0, 255));
	endfunction

	task automatic send_char(input logic [CharW-1:0] c);
		int gap;
		gap = (!calm && $urandom_range(0, 99) < 10) ? $urandom_range(1, 5) : 0;
		if (gap != 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_segments.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx <= REG_WORD_GAP)
			tick_regs[idx] = val;
	endtask

	task automatic set_ticks(input logic [TickW-1:0] dit, input logic [TickW-1:0] dah,
			input logic [TickW-1:0] elem, input logic [TickW-1:0] chr,
			input logic [TickW-1:0] wrd);
		write_reg(REG_DIT, dit);
		write_reg(REG_DAH, dah);
		write_reg(REG_ELEM_GAP, elem);
		write_reg(REG_CHAR_GAP, chr);
		write_reg(REG_WORD_GAP, wrd);
	endtask

	always @(negedge clk)
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);

	always @(posedge clk) begin : check_output
		segment_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_segments.size() == 0) begin
				flag_mismatch("segment with none pending, ticks", m_axis_tdata[8:1], 0);
			end else begin
				want = pending_segments.pop_front();
				if (m_axis_tdata[0] !== want.key_on)
					flag_mismatch("key_on", m_axis_tdata[0], want.key_on);
				if (m_axis_tdata[8:1] !== want.ticks)
					flag_mismatch("duration_ticks", m_axis_tdata[8:1], want.ticks);
				if (m_axis_tuser !== want.bad)
					flag_mismatch("bad_char", m_axis_tuser, want.bad);
				if (m_axis_tlast !== want.last)
					flag_mismatch("last", m_axis_tlast, want.last);
			end
		end
	end

	initial begin
		#400_000;
		$display("morse_code_keyer_test NOT OK");
		$finish;
	end

	initial begin
		tick_regs[REG_DIT] = 8'd2;
		tick_regs[REG_DAH] = 8'd5;
		tick_regs[REG_ELEM_GAP] = 8'd2;
		tick_regs[REG_CHAR_GAP] = 8'd5;
		tick_regs[REG_WORD_GAP] = 8'd8;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < 24; r++) begin
			send_char(DIRECTED[r].ch);
			if (DIRECTED[r].typed)
				pending_segments.push_back(segment_t'{1'b0, DIRECTED[r].ticks,
					DIRECTED[r].bad, 1'b1});
			else
				predict_segments(DIRECTED[r].ch);
		end

		for (int phase = 0; phase < 6; phase++) begin
			if (phase != 0)
				drain();
			calm = (phase == 3);
			case (phase)
				1: set_ticks(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
				2: begin
					set_ticks(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
					for (int spare = int'(REG_WORD_GAP) + 1; spare < (1 << CfgIdxW); spare++)
						write_reg(CfgIdxW'(spare), 8'h00);
				end
				3: set_ticks(8'd0, 8'd255, 8'd0, 8'd1, 8'd0);
				4, 5: set_ticks(TickW'($urandom_range(1, 255)), TickW'($urandom_range(1, 255)),
					TickW'($urandom_range(1, 255)), TickW'($urandom_range(1, 255)),
					TickW'($urandom_range(1, 255)));
				default: ;
			endcase
			for (int i = 0; i < 58; i++) begin
				logic [CharW-1:0] c;
				if (phase == 2 && i == 20)
					drain();
				c = random_char();
				send_char(c);
				predict_segments(c);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (pending_segments.size() != 0)
			flag_mismatch("segments never delivered", pending_segments.size(), 0);
		if (mismatches == 0) begin
			$display("morse_code_keyer_test OK");
		end else begin
			$display("morse_code_keyer_test NOT OK");
		end
		$finish;
	end

endmodule
